// ===== design/bfm_pkg.sv =====
// Shared constants, types and the microcode table of the tape machine step unit.
package bfm_pkg;

   localparam int CELL_COUNT = 32768;
   localparam int CODE_DEPTH = 4096;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int CADDR_W    = $clog2(CODE_DEPTH);
   localparam int LEN_W      = $clog2(CODE_DEPTH + 1);
   localparam int OP_W       = 2;
   localparam int BYTE_W     = 8;
   localparam int ERR_W      = 2;
   localparam int STEP_W     = 5;

   localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] CH_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_IN    = 8'h2C;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE   = 2'd0,
      ERR_SYNTAX = 2'd1,
      ERR_TOP    = 2'd2,
      ERR_BOTTOM = 2'd3
   } err_type;

   typedef enum logic [STEP_W-1:0] {
      S_CLR,
      S_IDLE,
      S_DISP,
      S_SCAN_RD,
      S_SCAN_CK,
      S_FIN,
      S_CLEAR,
      S_LOAD,
      S_REPORT,
      S_HALT_SYN,
      S_HALT_END,
      S_HALT_TOP,
      S_HALT_BOT,
      S_RIGHT,
      S_LEFT,
      S_NEXT,
      S_INC,
      S_DEC,
      S_IN,
      S_OUT,
      S_SCAN_F,
      S_SCAN_B
   } step_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ACCEPT,
      ACT_CLR_CELL,
      ACT_CLEAR_ALL,
      ACT_LOAD,
      ACT_HALT,
      ACT_RIGHT,
      ACT_LEFT,
      ACT_NEXT,
      ACT_INC,
      ACT_DEC,
      ACT_IN,
      ACT_OUT,
      ACT_SCAN_INIT,
      ACT_SCAN_RD,
      ACT_SCAN_CK
   } act_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CLR_MORE,
      COND_SCAN_END,
      COND_SCAN_MISS
   } cond_type;

   typedef enum logic {
      NXT_JUMP,
      NXT_DISP
   } nxt_type;

   typedef struct packed {
      nxt_type  nxt;
      cond_type cond;
      step_type target;
      act_type  act;
      err_type  reason;
      logic     scan_rd;
      logic     scan_back;
      logic     res_wr;
   } ucode_type;

   typedef struct packed {
      logic     req_pending;
      logic     rsp_busy;
      logic     clr_more;
      logic     scan_end;
      logic     scan_miss;
      step_type disp;
   } dp_stat_type;

   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      w = '{nxt: NXT_JUMP, cond: COND_ALWAYS, target: S_IDLE, act: ACT_NONE,
            reason: ERR_NONE, scan_rd: 1'b0, scan_back: 1'b0, res_wr: 1'b1};
      unique case (s)
         S_CLR: begin
            w.cond = COND_CLR_MORE; w.target = S_CLR; w.act = ACT_CLR_CELL; w.res_wr = 1'b0;
         end
         S_IDLE: begin
            w.cond = COND_NO_REQ; w.target = S_IDLE; w.act = ACT_ACCEPT; w.res_wr = 1'b0;
         end
         S_DISP: begin
            w.nxt = NXT_DISP; w.res_wr = 1'b0;
         end
         S_SCAN_RD: begin
            w.cond = COND_SCAN_END; w.target = S_HALT_SYN; w.act = ACT_SCAN_RD;
            w.scan_rd = 1'b1; w.res_wr = 1'b0;
         end
         S_SCAN_CK: begin
            w.cond = COND_SCAN_MISS; w.target = S_SCAN_RD; w.act = ACT_SCAN_CK;
            w.res_wr = 1'b0;
         end
         S_FIN:      w.act = ACT_NONE;
         S_CLEAR: begin
            w.act = ACT_CLEAR_ALL; w.target = S_CLR;
         end
         S_LOAD:     w.act = ACT_LOAD;
         S_REPORT:   w.act = ACT_NONE;
         S_HALT_SYN: begin
            w.act = ACT_HALT; w.reason = ERR_SYNTAX;
         end
         S_HALT_END: begin
            w.act = ACT_HALT; w.reason = ERR_NONE;
         end
         S_HALT_TOP: begin
            w.act = ACT_HALT; w.reason = ERR_TOP;
         end
         S_HALT_BOT: begin
            w.act = ACT_HALT; w.reason = ERR_BOTTOM;
         end
         S_RIGHT:    w.act = ACT_RIGHT;
         S_LEFT:     w.act = ACT_LEFT;
         S_NEXT:     w.act = ACT_NEXT;
         S_INC:      w.act = ACT_INC;
         S_DEC:      w.act = ACT_DEC;
         S_IN:       w.act = ACT_IN;
         S_OUT:      w.act = ACT_OUT;
         S_SCAN_F: begin
            w.act = ACT_SCAN_INIT; w.target = S_SCAN_RD; w.res_wr = 1'b0;
         end
         S_SCAN_B: begin
            w.act = ACT_SCAN_INIT; w.target = S_SCAN_RD; w.scan_back = 1'b1;
            w.res_wr = 1'b0;
         end
         default: begin
            w.res_wr = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/bfm_if.sv =====
// Request and response channel interfaces of the tape machine step unit.
interface bfm_req_if;
   import bfm_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [BYTE_W-1:0] code_byte;
   logic              in_valid;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, operation, code_byte, in_valid, in_byte, input ready);
   modport sink (input valid, operation, code_byte, in_valid, in_byte, output ready);
endinterface

interface bfm_rsp_if;
   import bfm_pkg::*;
   logic              valid;
   logic              ready;
   logic              out_valid;
   logic [BYTE_W-1:0] out_byte;
   logic              input_used;
   logic              halted;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, out_valid, out_byte, input_used, halted, error_code,
                   input ready);
   modport sink (input valid, out_valid, out_byte, input_used, halted, error_code,
                 output ready);
endinterface

// ===== design/bfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module bfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/bfm_seq.sv =====
// Microcode sequencer: step counter, control word table and next-step selection.
module bfm_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  bfm_pkg::dp_stat_type stat,
   output bfm_pkg::ucode_type   ctl,
   output logic                 fire
);
   import bfm_pkg::*;

   step_type upc_ff;
   step_type upc_in;
   logic     cond_hit;
   logic     stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_CLR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      ctl   = ucode_rom(upc_ff);
      stall = ctl.res_wr && stat.rsp_busy;
      fire  = !stall;
      unique case (ctl.cond)
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_NO_REQ:    cond_hit = !stat.req_pending;
         COND_CLR_MORE:  cond_hit = stat.clr_more;
         COND_SCAN_END:  cond_hit = stat.scan_end;
         COND_SCAN_MISS: cond_hit = stat.scan_miss;
         default:        cond_hit = 1'b0;
      endcase
      if (stall) begin
         upc_in = upc_ff;
      end else if (ctl.nxt == NXT_DISP) begin
         upc_in = stat.disp;
      end else if (cond_hit) begin
         upc_in = ctl.target;
      end else begin
         upc_in = step_type'(STEP_W'(upc_ff) + STEP_W'(1));
      end
   end

endmodule

// ===== design/bfm_dp.sv =====
// Datapath: machine registers, code and cell memories, request capture and result register.
module bfm_dp (
   input  logic                 clock,
   input  logic                 reset,
   bfm_req_if.sink              req_bus,
   bfm_rsp_if.source            rsp_bus,
   input  bfm_pkg::ucode_type   ctl,
   input  logic                 fire,
   output bfm_pkg::dp_stat_type stat
);
   import bfm_pkg::*;

   logic [OP_W-1:0]    op_ff;
   logic [BYTE_W-1:0]  code_byte_ff;
   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;

   logic [LEN_W-1:0]   code_length_ff, code_length_in;
   logic [LEN_W-1:0]   pc_ff, pc_in;
   logic [CELL_W-1:0]  dp_ff, dp_in;
   logic [LEN_W-1:0]   load_depth_ff, load_depth_in;
   logic               syntax_bad_ff, syntax_bad_in;
   logic               stopped_ff, stopped_in;
   err_type            reason_ff, reason_in;
   logic [CELL_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [LEN_W-1:0]   scan_ff, scan_in;
   logic [LEN_W-1:0]   level_ff, level_in;
   logic               scan_back_ff, scan_back_in;

   logic               rsp_valid_ff;
   logic               rsp_out_valid_ff;
   logic [BYTE_W-1:0]  rsp_out_byte_ff;
   logic               rsp_input_used_ff;
   logic               rsp_halted_ff;
   err_type            rsp_error_ff;

   logic               accept;
   logic               rsp_load;
   logic [LEN_W-1:0]   scan_nxt;
   logic [BYTE_W-1:0]  same_ch;
   logic [BYTE_W-1:0]  opp_ch;
   logic               scan_hit;
   step_type           disp;

   logic               code_we;
   logic [CADDR_W-1:0] code_raddr;
   logic [BYTE_W-1:0]  code_rdata;
   logic               cell_we;
   logic [CELL_W-1:0]  cell_waddr;
   logic [BYTE_W-1:0]  cell_wdata;
   logic [BYTE_W-1:0]  cell_rdata;

   logic               res_out_valid;
   logic [BYTE_W-1:0]  res_out_byte;
   logic               res_input_used;

   bfm_ram #(.WIDTH(BYTE_W), .DEPTH(CODE_DEPTH)) u_code_ram (
      .clock (clock),
      .we    (code_we),
      .waddr (code_length_ff[CADDR_W-1:0]),
      .wdata (code_byte_ff),
      .raddr (code_raddr),
      .rdata (code_rdata)
   );

   bfm_ram #(.WIDTH(BYTE_W), .DEPTH(CELL_COUNT)) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata (cell_wdata),
      .raddr (dp_ff),
      .rdata (cell_rdata)
   );

   assign req_bus.ready = (ctl.act == ACT_ACCEPT);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_load      = fire && ctl.res_wr;

   assign scan_nxt   = scan_back_ff ? (scan_ff - LEN_W'(1)) : (scan_ff + LEN_W'(1));
   assign code_raddr = ctl.scan_rd ? scan_nxt[CADDR_W-1:0] : pc_ff[CADDR_W-1:0];
   assign same_ch    = scan_back_ff ? CH_CLOSE : CH_OPEN;
   assign opp_ch     = scan_back_ff ? CH_OPEN : CH_CLOSE;
   assign scan_hit   = (code_rdata == opp_ch) && (level_ff == LEN_W'(1));

   assign stat.req_pending = req_bus.valid;
   assign stat.rsp_busy    = rsp_valid_ff && !rsp_bus.ready;
   assign stat.clr_more    = (clr_addr_ff != CELL_W'(CELL_COUNT - 1));
   assign stat.scan_end    = scan_back_ff ? (scan_ff == '0) : (scan_nxt >= code_length_ff);
   assign stat.scan_miss   = !scan_hit;
   assign stat.disp        = disp;

   // The opcode and the current cell arrive from the reads issued while idle.
   always_comb begin
      unique case (op_ff)
         OP_CLEAR: disp = S_CLEAR;
         OP_LOAD:  disp = S_LOAD;
         OP_STEP: begin
            priority if (stopped_ff) begin
               disp = S_REPORT;
            end else if (syntax_bad_ff || (load_depth_ff != '0)) begin
               disp = S_HALT_SYN;
            end else if (pc_ff >= code_length_ff) begin
               disp = S_HALT_END;
            end else begin
               unique case (code_rdata)
                  CH_RIGHT: disp = (dp_ff == CELL_W'(CELL_COUNT - 1)) ? S_HALT_TOP : S_RIGHT;
                  CH_LEFT:  disp = (dp_ff == '0) ? S_HALT_BOT : S_LEFT;
                  CH_OPEN:  disp = (cell_rdata == '0) ? S_SCAN_F : S_NEXT;
                  CH_CLOSE: disp = (cell_rdata != '0) ? S_SCAN_B : S_NEXT;
                  CH_INC:   disp = S_INC;
                  CH_DEC:   disp = S_DEC;
                  CH_OUT:   disp = S_OUT;
                  CH_IN:    disp = S_IN;
                  default:  disp = S_NEXT;
               endcase
            end
         end
         default:  disp = S_REPORT;
      endcase
   end

   always_comb begin
      code_length_in = code_length_ff;
      pc_in          = pc_ff;
      dp_in          = dp_ff;
      load_depth_in  = load_depth_ff;
      syntax_bad_in  = syntax_bad_ff;
      stopped_in     = stopped_ff;
      reason_in      = reason_ff;
      clr_addr_in    = clr_addr_ff;
      scan_in        = scan_ff;
      level_in       = level_ff;
      scan_back_in   = scan_back_ff;
      code_we        = 1'b0;
      cell_we        = 1'b0;
      cell_waddr     = dp_ff;
      cell_wdata     = cell_rdata;
      if (fire) begin
         unique case (ctl.act)
            ACT_CLR_CELL: begin
               cell_we     = 1'b1;
               cell_waddr  = clr_addr_ff;
               cell_wdata  = '0;
               clr_addr_in = stat.clr_more ? (clr_addr_ff + CELL_W'(1)) : '0;
            end
            ACT_CLEAR_ALL: begin
               code_length_in = '0;
               pc_in          = '0;
               dp_in          = '0;
               load_depth_in  = '0;
               syntax_bad_in  = 1'b0;
               stopped_in     = 1'b0;
               reason_in      = ERR_NONE;
               clr_addr_in    = '0;
            end
            ACT_LOAD: begin
               if (code_length_ff < LEN_W'(CODE_DEPTH)) begin
                  code_we        = 1'b1;
                  code_length_in = code_length_ff + LEN_W'(1);
                  if (!syntax_bad_ff) begin
                     if (code_byte_ff == CH_OPEN) begin
                        load_depth_in = load_depth_ff + LEN_W'(1);
                     end else if (code_byte_ff == CH_CLOSE) begin
                        if (load_depth_ff == '0) begin
                           syntax_bad_in = 1'b1;
                        end else begin
                           load_depth_in = load_depth_ff - LEN_W'(1);
                        end
                     end
                  end
               end
            end
            ACT_HALT: begin
               stopped_in = 1'b1;
               reason_in  = ctl.reason;
            end
            ACT_RIGHT: begin
               dp_in = dp_ff + CELL_W'(1);
               pc_in = pc_ff + LEN_W'(1);
            end
            ACT_LEFT: begin
               dp_in = dp_ff - CELL_W'(1);
               pc_in = pc_ff + LEN_W'(1);
            end
            ACT_NEXT, ACT_OUT: begin
               pc_in = pc_ff + LEN_W'(1);
            end
            ACT_INC: begin
               cell_we    = 1'b1;
               cell_wdata = cell_rdata + BYTE_W'(1);
               pc_in      = pc_ff + LEN_W'(1);
            end
            ACT_DEC: begin
               cell_we    = 1'b1;
               cell_wdata = cell_rdata - BYTE_W'(1);
               pc_in      = pc_ff + LEN_W'(1);
            end
            ACT_IN: begin
               cell_we    = in_valid_ff;
               cell_wdata = in_byte_ff;
               pc_in      = pc_ff + LEN_W'(1);
            end
            ACT_SCAN_INIT: begin
               scan_in      = pc_ff;
               level_in     = LEN_W'(1);
               scan_back_in = ctl.scan_back;
            end
            ACT_SCAN_RD: begin
               scan_in = scan_nxt;
            end
            ACT_SCAN_CK: begin
               if (scan_hit) begin
                  pc_in = scan_ff + LEN_W'(1);
               end else if (code_rdata == same_ch) begin
                  level_in = level_ff + LEN_W'(1);
               end else if (code_rdata == opp_ch) begin
                  level_in = level_ff - LEN_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign res_out_valid  = (ctl.act == ACT_OUT);
   assign res_out_byte   = (ctl.act == ACT_OUT) ? cell_rdata : '0;
   assign res_input_used = (ctl.act == ACT_IN) && in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_length_ff <= '0;
         pc_ff          <= '0;
         dp_ff          <= '0;
         load_depth_ff  <= '0;
         syntax_bad_ff  <= 1'b0;
         stopped_ff     <= 1'b0;
         reason_ff      <= ERR_NONE;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         code_length_ff <= code_length_in;
         pc_ff          <= pc_in;
         dp_ff          <= dp_in;
         load_depth_ff  <= load_depth_in;
         syntax_bad_ff  <= syntax_bad_in;
         stopped_ff     <= stopped_in;
         reason_ff      <= reason_in;
         clr_addr_ff    <= clr_addr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      level_ff     <= level_in;
      scan_back_ff <= scan_back_in;
      if (accept) begin
         op_ff        <= req_bus.operation;
         code_byte_ff <= req_bus.code_byte;
         in_valid_ff  <= req_bus.in_valid;
         in_byte_ff   <= req_bus.in_byte;
      end
      if (rsp_load) begin
         rsp_out_valid_ff  <= res_out_valid;
         rsp_out_byte_ff   <= res_out_byte;
         rsp_input_used_ff <= res_input_used;
         rsp_halted_ff     <= stopped_in;
         rsp_error_ff      <= reason_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_valid  = rsp_out_valid_ff;
   assign rsp_bus.out_byte   = rsp_out_byte_ff;
   assign rsp_bus.input_used = rsp_input_used_ff;
   assign rsp_bus.halted     = rsp_halted_ff;
   assign rsp_bus.error_code = rsp_error_ff;

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      (code_length_ff <= LEN_W'(CODE_DEPTH)) && (pc_ff <= code_length_ff))
      else $error("Program counter or code length out of range.");

   a_stopped_no_cell_write: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> !cell_we)
      else $error("A stopped machine wrote a data cell.");

   a_syntax_sticky: assert property (@(posedge clock) disable iff (reset)
      syntax_bad_ff && !(fire && (ctl.act == ACT_CLEAR_ALL)) |=> syntax_bad_ff)
      else $error("The bracket error flag dropped without a clear.");

   a_accept_then_dispatch: assert property (@(posedge clock) disable iff (reset)
      accept |=> (ctl.nxt == NXT_DISP) && !rsp_load)
      else $error("An accepted request was not dispatched in the next cycle.");

endmodule

// ===== design/bf_machine_step_unit.sv =====
// Top level of the tape machine step unit: microcode sequencer and datapath.
//
//   channel  | dir | ports      | payload
//   ---------+-----+------------+-----------------------------------------------
//   request  | in  | req_bus    | operation, code_byte, in_valid, in_byte
//   response | out | rsp_bus    | out_valid, out_byte, input_used, halted, error_code
//
// Every request gives one response. A clear, load or simple step request passes through the
// accept and read, dispatch and execute steps, and its response is registered by the execute step.
// A bracket jump passes through accept, dispatch and scan setup, then one code memory read and
// one check step per scanned byte, then a finish step, or a syntax halt if no partner is found.
// After reset and after every clear request, a sweep zeroes the 32768 data cells at one
// cell per cycle, and no request is accepted during the sweep.
// The execute step waits while the previous response is still unread; the result register
// lets a new request be accepted while a response is still waiting.
module bf_machine_step_unit (
   input logic       clock,
   input logic       reset,
   bfm_req_if.sink   req_bus,
   bfm_rsp_if.source rsp_bus
);
   import bfm_pkg::*;

   ucode_type   ctl;
   logic        fire;
   dp_stat_type stat;

   bfm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl),
      .fire  (fire)
   );

   bfm_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .ctl     (ctl),
      .fire    (fire),
      .stat    (stat)
   );

endmodule

// ===== tb/bfm_step_check.sv =====
// Response predictor and comparator for the tape machine step unit.
`timescale 1ns / 100ps
module bfm_step_check (
   input  logic clock,
   input  logic reset,
   bfm_req_if   req_mon,
   bfm_rsp_if   rsp_mon,
   output int   failures,
   output int   pending
);
   import bfm_pkg::*;

   typedef struct packed {
      logic              out_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              input_used;
      logic              halted;
      err_type           error_code;
   } step_result;

   logic [BYTE_W-1:0] program_bytes [CODE_DEPTH];
   logic [BYTE_W-1:0] tape [CELL_COUNT];
   logic [LEN_W-1:0]  program_len;
   logic [LEN_W-1:0]  instr_ptr;
   logic [CELL_W-1:0] head;
   logic [13:0]       bracket_depth;
   logic              bracket_broken;
   logic              machine_stopped;
   err_type           stop_cause;
   step_result        result_queue [$];

   function automatic void wipe_machine();
      foreach (tape[i]) tape[i] = '0;
      program_len = '0;
      instr_ptr = '0;
      head = '0;
      bracket_depth = '0;
      bracket_broken = 1'b0;
      machine_stopped = 1'b0;
      stop_cause = ERR_NONE;
   endfunction

   function automatic void stop_machine(input err_type why);
      machine_stopped = 1'b1;
      stop_cause = why;
   endfunction

   // Walks the program from a bracket to its partner in either direction.
   function automatic bit find_partner(input int from, input bit backward, output int hit);
      int level;
      int i;
      logic [BYTE_W-1:0] nest;
      logic [BYTE_W-1:0] unnest;
      level = 1;
      nest = backward ? CH_CLOSE : CH_OPEN;
      unnest = backward ? CH_OPEN : CH_CLOSE;
      i = backward ? from - 1 : from + 1;
      hit = 0;
      while (i >= 0 && i < int'(program_len)) begin
         if (program_bytes[i] == nest) begin
            level++;
         end else if (program_bytes[i] == unnest) begin
            level--;
            if (level == 0) begin
               hit = i;
               return 1'b1;
            end
         end
         i = backward ? i - 1 : i + 1;
      end
      return 1'b0;
   endfunction

   function automatic void execute_one(input logic in_ok, input logic [BYTE_W-1:0] in_data,
                                       inout step_result r);
      int pc;
      int hit;
      logic [BYTE_W-1:0] opc;
      pc = instr_ptr;
      if (bracket_broken || bracket_depth != 0) begin
         stop_machine(ERR_SYNTAX);
         return;
      end
      if (pc >= int'(program_len)) begin
         stop_machine(ERR_NONE);
         return;
      end
      opc = program_bytes[pc];
      case (opc)
         CH_RIGHT: begin
            if (head == CELL_COUNT - 1) begin
               stop_machine(ERR_TOP);
               return;
            end
            head = head + 1'b1;
         end
         CH_LEFT: begin
            if (head == 0) begin
               stop_machine(ERR_BOTTOM);
               return;
            end
            head = head - 1'b1;
         end
         CH_OPEN: begin
            if (tape[head] == 0) begin
               if (!find_partner(pc, 1'b0, hit)) begin
                  stop_machine(ERR_SYNTAX);
                  return;
               end
               pc = hit;
            end
         end
         CH_CLOSE: begin
            if (tape[head] != 0) begin
               if (!find_partner(pc, 1'b1, hit)) begin
                  stop_machine(ERR_SYNTAX);
                  return;
               end
               pc = hit;
            end
         end
         CH_OUT: begin
            r.out_valid = 1'b1;
            r.out_byte = tape[head];
         end
         CH_IN: begin
            if (in_ok) begin
               tape[head] = in_data;
               r.input_used = 1'b1;
            end
         end
         CH_INC: tape[head] = tape[head] + 8'd1;
         CH_DEC: tape[head] = tape[head] - 8'd1;
         default: ;
      endcase
      instr_ptr = LEN_W'(pc + 1);
   endfunction

   function automatic step_result predict_response(input logic [OP_W-1:0] op,
                                                   input logic [BYTE_W-1:0] code,
                                                   input logic in_ok,
                                                   input logic [BYTE_W-1:0] in_data);
      step_result r;
      r = '0;
      if (op == OP_CLEAR) begin
         wipe_machine();
         return r;
      end
      if (op == OP_LOAD) begin
         if (program_len < CODE_DEPTH) begin
            program_bytes[program_len[CADDR_W-1:0]] = code;
            program_len = program_len + 1'b1;
            if (!bracket_broken) begin
               if (code == CH_OPEN) begin
                  bracket_depth = bracket_depth + 1'b1;
               end else if (code == CH_CLOSE) begin
                  if (bracket_depth == 0) bracket_broken = 1'b1;
                  else bracket_depth = bracket_depth - 1'b1;
               end
            end
         end
      end else if (op == OP_STEP && !machine_stopped) begin
         execute_one(in_ok, in_data, r);
      end
      r.halted = machine_stopped;
      r.error_code = stop_cause;
      return r;
   endfunction

   function automatic void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      step_result want;
      if (reset) begin
         wipe_machine();
         result_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t: response with no request waiting, actual halted %0d error %0d",
                        $time, rsp_mon.halted, rsp_mon.error_code);
               failures++;
            end else begin
               want = result_queue.pop_front();
               compare_field("out_valid", want.out_valid, rsp_mon.out_valid);
               compare_field("out_byte", want.out_byte, rsp_mon.out_byte);
               compare_field("input_used", want.input_used, rsp_mon.input_used);
               compare_field("halted", want.halted, rsp_mon.halted);
               compare_field("error_code", want.error_code, rsp_mon.error_code);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            result_queue.push_back(predict_response(req_mon.operation, req_mon.code_byte,
                                                    req_mon.in_valid, req_mon.in_byte));
         end
      end
      pending <= result_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the tape machine step unit testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb;
   import bfm_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 560;

   logic clock;
   logic reset;
   int   failures;
   int   pending;

   bfm_req_if req_bus();
   bfm_rsp_if rsp_bus();

   bf_machine_step_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   bfm_step_check step_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .failures (failures),
      .pending  (pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == CH_OPEN || v == CH_CLOSE);
      return v;
   endfunction

   task automatic send_req(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] code,
                           input logic in_ok, input logic [BYTE_W-1:0] in_data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.code_byte <= code;
      req_bus.in_valid <= in_ok;
      req_bus.in_byte <= in_data;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic clear_machine();
      send_req(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
   endtask

   task automatic load_code(input logic [BYTE_W-1:0] b);
      send_req(OP_LOAD, b, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   task automatic step_machine(input logic in_ok, input logic [BYTE_W-1:0] in_data);
      send_req(OP_STEP, 8'($urandom_range(0, 255)), in_ok, in_data);
   endtask

   task automatic send_spare();
      send_req(OP_SPARE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)));
   endtask

   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         int n;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0] basic_prog [13];
      logic [BYTE_W-1:0] prog [$];
      logic [BYTE_W-1:0] b;
      int random_sent;
      int len;
      int depth;
      int r;
      int n;

      random_sent = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_CLEAR;
      req_bus.code_byte <= '0;
      req_bus.in_valid <= 1'b0;
      req_bus.in_byte <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // An empty program halts at once; the spare operation only reports status.
      step_machine(1'b1, 8'h00);
      send_spare();
      step_machine(1'b0, 8'hFF);

      basic_prog = '{CH_IN, CH_OUT, CH_IN, CH_OUT, CH_INC, CH_OUT, CH_DEC, CH_OUT,
                     8'h00, 8'hFF, CH_RIGHT, CH_LEFT, CH_LEFT};
      clear_machine();
      foreach (basic_prog[i]) load_code(basic_prog[i]);
      step_machine(1'b1, 8'hFF);
      step_machine(1'b1, 8'h00);
      step_machine(1'b0, 8'h5A);
      repeat (11) step_machine(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      // A closing bracket before any opening one is a syntax error even when balanced.
      clear_machine();
      load_code(CH_CLOSE);
      load_code(CH_OPEN);
      step_machine(1'b1, 8'h01);
      step_machine(1'b1, 8'h01);

      while (random_sent < RANDOM_ITEMS) begin
         clear_machine();
         prog.delete();
         len = $urandom_range(4, 40);
         depth = 0;
         repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 14) b = CH_RIGHT;
            else if (r < 22) b = CH_LEFT;
            else if (r < 40) b = CH_INC;
            else if (r < 52) b = CH_DEC;
            else if (r < 62) b = CH_OUT;
            else if (r < 72) b = CH_IN;
            else if (r < 84) b = CH_OPEN;
            else if (r < 94) b = CH_CLOSE;
            else b = plain_byte();
            if (b == CH_OPEN) begin
               depth++;
            end else if (b == CH_CLOSE) begin
               if (depth == 0) b = CH_INC;
               else depth--;
            end
            prog.push_back(b);
         end
         repeat (depth) prog.push_back(CH_CLOSE);
         if ($urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 1) == 0) prog.push_front(CH_CLOSE);
            else prog.push_back(CH_OPEN);
         end
         foreach (prog[i]) begin
            if ($urandom_range(0, 19) == 0) send_spare();
            load_code(prog[i]);
         end
         n = $urandom_range(20, 80);
         repeat (n) begin
            r = $urandom_range(0, 19);
            if (r == 0) send_spare();
            else if (r == 1) load_code(8'($urandom_range(0, 255)));
            else step_machine($urandom_range(0, 3) != 0,
                              ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
         end
         random_sent += prog.size() + n;
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
